/* rtl/assert_macros.svh */
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every edge outside reset
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// implication checked at every edge, reset included
`define ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) (prop)) else $error("assertion failed");

`endif

/* rtl/staa_pkg.sv */
// ----------------------------------------------------------------------------
// staa_pkg
// shared constants, types and helpers of the sensor table aging core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package staa_pkg;

   localparam int unsigned TABLE_DEPTH_DEF = 16;
   localparam logic [15:0] EXPIRY_RESET    = 16'd60;
   localparam logic        CMD_STORE       = 1'b0;
   localparam logic        CMD_QUERY       = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_INSERT,
      ST_DIV,
      ST_DONE
   } state_type;

   // age = now - stamp, never wraps; negative age is never expired
   function automatic logic is_expired(input logic [31:0] now, input logic [31:0] stamp,
                                       input logic [15:0] limit);
      logic signed [33:0] age;
      begin
         age = $signed({{2{now[31]}}, now}) - $signed({{2{stamp[31]}}, stamp});
         is_expired = age > $signed({18'd0, limit});
      end
   endfunction

endpackage

/* rtl/sensor_table_aging_average_core.sv */
// ----------------------------------------------------------------------------
// sensor_table_aging_average_core
// slot table with expiry, update or insert, and mean of live temperatures
// ----------------------------------------------------------------------------
// channel | dir | tdata / data fields (low bit up)                  | tuser
// req     | in  | node_address, temperature, sample_time, current_time | cmd
// rsp     | out | mean_temp, live_count, update_dropped, zero pad     | -
// csr     | in  | expiry_seconds                                     | -
//
// one word passes the memory scan (read then evaluate, one slot a cycle),
// insert, the bit-serial divider (load, then one bit a cycle) and the
// result load, and then goes back to idle.
// reset clears the valid bits at once; slot data needs no clearing.
// req is taken while a result waits; a stalled rsp holds the next result.
`timescale 1ns / 1ps
module sensor_table_aging_average_core #(
   parameter int unsigned TABLE_DEPTH = staa_pkg::TABLE_DEPTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,  // node_address, temperature, sample_time, current_time
   input  logic [0:0]   req_tuser,  // cmd
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [39:0]  rsp_tdata,  // mean_temp, live_count, update_dropped, pad
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [15:0]  csr_data    // expiry_seconds
);
   import staa_pkg::*;

   localparam int unsigned IW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int unsigned CNW = $clog2(TABLE_DEPTH + 1);
   localparam int unsigned SW  = 32 + IW + 1;
   localparam int unsigned DCW = $clog2(SW + 1);

   logic [95:0] mem [TABLE_DEPTH];
   logic [95:0] rdata_ff;
   logic        we;
   logic [IW-1:0] waddr;
   logic [95:0] wdata;
   logic [IW-1:0] raddr;

   state_type state_ff, state_in;
   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;
   logic [15:0]   expiry_ff, expiry_in;
   logic          cmd_ff, cmd_in;
   logic [31:0]   addr_ff, addr_in, temp_ff, temp_in, stime_ff, stime_in, now_ff, now_in;
   logic [CNW-1:0] cnt_ff, cnt_in, live_ff, live_in;
   logic signed [SW-1:0] sum_ff, sum_in;
   logic          matched_ff, matched_in, free_ok_ff, free_ok_in, drop_ff, drop_in;
   logic [IW-1:0] free_idx_ff, free_idx_in;
   logic [SW-1:0] dvd_ff, dvd_in;
   logic [CNW:0]  rem_ff, rem_in;
   logic [DCW-1:0] step_ff, step_in;
   logic          neg_ff, neg_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [39:0]   rsp_data_ff, rsp_data_in;

   logic [IW-1:0] eidx;
   logic [CNW-1:0] cnt_m1;
   logic          e_valid, e_exp, e_match, new_exp;
   logic [CNW:0]  rem_sh;
   logic [31:0]   quo;
   logic [SW-1:0] sum_mag;

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign cnt_m1  = cnt_ff - 1'b1;
   assign eidx    = cnt_m1[IW-1:0];
   assign raddr   = cnt_ff[IW-1:0];
   assign e_valid = valid_ff[eidx];
   assign e_exp   = is_expired(now_ff, rdata_ff[95:64], expiry_ff);
   assign e_match = (rdata_ff[31:0] == addr_ff);
   assign new_exp = is_expired(now_ff, stime_ff, expiry_ff);
   assign rem_sh  = {rem_ff[CNW-1:0], dvd_ff[SW-1]};
   assign sum_mag = sum_ff[SW-1] ? SW'(-sum_ff) : SW'(sum_ff);
   assign quo     = neg_ff ? 32'(-dvd_ff) : dvd_ff[31:0];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   always_comb begin
      state_in    = state_ff;
      valid_in    = valid_ff;
      expiry_in   = expiry_ff;
      cmd_in      = cmd_ff;
      addr_in     = addr_ff;
      temp_in     = temp_ff;
      stime_in    = stime_ff;
      now_in      = now_ff;
      cnt_in      = cnt_ff;
      live_in     = live_ff;
      sum_in      = sum_ff;
      matched_in  = matched_ff;
      free_ok_in  = free_ok_ff;
      free_idx_in = free_idx_ff;
      drop_in     = drop_ff;
      dvd_in      = dvd_ff;
      rem_in      = rem_ff;
      step_in     = step_ff;
      neg_in      = neg_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      we    = 1'b0;
      waddr = eidx;
      wdata = {stime_ff, temp_ff, addr_ff};

      if (csr_valid) begin
         expiry_in = csr_data;
      end
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd_in     = req_tuser[0];
               addr_in    = req_tdata[31:0];
               temp_in    = req_tdata[63:32];
               stime_in   = req_tdata[95:64];
               now_in     = req_tdata[127:96];
               cnt_in     = '0;
               live_in    = '0;
               sum_in     = '0;
               matched_in = 1'b0;
               free_ok_in = 1'b0;
               free_idx_in = '0;
               drop_in    = 1'b0;
               state_in   = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (cnt_ff != '0) begin
               if (cmd_ff == CMD_STORE) begin
                  if (e_valid && e_exp) begin
                     valid_in[eidx] = 1'b0;
                  end else if (e_valid && e_match) begin
                     we = 1'b1;
                     matched_in = 1'b1;
                  end
                  if ((!e_valid || e_exp) && !free_ok_in) begin
                     free_ok_in  = 1'b1;
                     free_idx_in = eidx;
                  end
               end
               if (e_valid && !e_exp) begin
                  if (cmd_ff == CMD_STORE && e_match) begin
                     if (!new_exp) begin
                        live_in = live_in + 1'b1;
                        sum_in  = sum_in + SW'($signed(temp_ff));
                     end
                  end else begin
                     live_in = live_in + 1'b1;
                     sum_in  = sum_in + SW'($signed(rdata_ff[63:32]));
                  end
               end
            end
            if (cnt_ff == CNW'(TABLE_DEPTH)) begin
               state_in = ST_INSERT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_INSERT: begin
            if (cmd_ff == CMD_STORE && !matched_ff) begin
               if (free_ok_ff) begin
                  we    = 1'b1;
                  waddr = free_idx_ff;
                  valid_in[free_idx_ff] = 1'b1;
                  if (!new_exp) begin
                     live_in = live_ff + 1'b1;
                     sum_in  = sum_ff + SW'($signed(temp_ff));
                  end
               end else begin
                  drop_in = 1'b1;
               end
            end
            step_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (step_ff == '0) begin
               dvd_in  = sum_mag;
               neg_in  = sum_ff[SW-1];
               rem_in  = '0;
               step_in = step_ff + 1'b1;
               if (live_ff == '0) begin
                  dvd_in   = '0;
                  neg_in   = 1'b0;
                  state_in = ST_DONE;
               end
            end else begin
               if (rem_sh >= {1'b0, live_ff}) begin
                  rem_in = rem_sh - {1'b0, live_ff};
                  dvd_in = {dvd_ff[SW-2:0], 1'b1};
               end else begin
                  rem_in = rem_sh;
                  dvd_in = {dvd_ff[SW-2:0], 1'b0};
               end
               if (step_ff == DCW'(SW)) begin
                  state_in = ST_DONE;
               end else begin
                  step_in = step_ff + 1'b1;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {2'b00, drop_ff, 5'(live_ff), quo};
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         expiry_ff    <= EXPIRY_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         expiry_ff    <= expiry_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      addr_ff     <= addr_in;
      temp_ff     <= temp_in;
      stime_ff    <= stime_in;
      now_ff      <= now_in;
      cnt_ff      <= cnt_in;
      live_ff     <= live_in;
      sum_ff      <= sum_in;
      matched_ff  <= matched_in;
      free_ok_ff  <= free_ok_in;
      free_idx_ff <= free_idx_in;
      drop_ff     <= drop_in;
      dvd_ff      <= dvd_in;
      rem_ff      <= rem_in;
      step_ff     <= step_in;
      neg_ff      <= neg_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

/* rtl/staa_checker.sv */
// ----------------------------------------------------------------------------
// staa_checker
// port-level checks of the sensor table aging core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module staa_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic        csr_ready
);
   `ASSERT_CLK(rsp_hold_chk, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
   `ASSERT_ALWAYS(rsp_reset_chk, clock, reset |=> !rsp_tvalid)
   `ASSERT_CLK(empty_avg_chk, clock, reset, rsp_tvalid && rsp_tdata[36:32] == 5'd0 |-> rsp_tdata[31:0] == 32'd0)
   `ASSERT_CLK(busy_chk, clock, reset, req_tvalid && req_tready |=> !req_tready && csr_ready)
endmodule

bind sensor_table_aging_average_core staa_checker u_staa_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .csr_ready  (csr_ready)
);
